/* rtl/brf_pkg.sv */
// Shared types and constants for the byte ring FIFO.
`timescale 1ns / 1ps
`default_nettype none
package brf_pkg;

    localparam int DATA_W = 64;
    localparam int REQ_W  = 4;
    localparam int FREE_W = 11;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic              action;
        logic [REQ_W-1:0]  byte_count;
        logic [DATA_W-1:0] write_data;
    } brf_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [REQ_W-1:0]  moved_count;
        logic              short_flag;
        logic [FREE_W-1:0] space_left;
        logic              empty_flag;
        logic              full_flag_out;
    } brf_result_t;

endpackage
`default_nettype wire

/* rtl/brf_if.sv */
// Valid/ready channel interfaces for the byte ring FIFO command and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface brf_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [brf_pkg::REQ_W-1:0]     byte_count;
    logic [brf_pkg::DATA_W-1:0]    write_data;

    modport source (output valid, action, byte_count, write_data, input ready);
    modport sink   (input valid, action, byte_count, write_data, output ready);
endinterface

interface brf_out_if;
    logic                          valid;
    logic                          ready;
    logic [brf_pkg::DATA_W-1:0]    read_data;
    logic [brf_pkg::REQ_W-1:0]     moved_count;
    logic                          short_flag;
    logic [brf_pkg::FREE_W-1:0]    space_left;
    logic                          empty_flag;
    logic                          full_flag_out;

    modport source (output valid, read_data, moved_count, short_flag, space_left,
                    empty_flag, full_flag_out, input ready);
    modport sink   (input valid, read_data, moved_count, short_flag, space_left,
                    empty_flag, full_flag_out, output ready);
endinterface
`default_nettype wire

/* rtl/brf_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/brf_seq.sv */
// Byte sequencer: pointers, fill count and one-byte-per-cycle RAM access.
`timescale 1ns / 1ps
`default_nettype none
module brf_seq #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BYTES = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_ready,
    input  wire brf_pkg::brf_cmd_t    cmd,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output brf_pkg::brf_result_t      res
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WIDE_W = (CNT_W > brf_pkg::FREE_W) ? CNT_W : brf_pkg::FREE_W;
    localparam int REQ_W  = brf_pkg::REQ_W;
    localparam int DATA_W = brf_pkg::DATA_W;
    localparam logic [REQ_W-1:0] MAX_REQ  = REQ_W'(MAX_BYTES);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        state_reg,     state_next;
    logic              act_reg,       act_next;
    logic [REQ_W-1:0]  req_reg,       req_next;
    logic [REQ_W-1:0]  moved_reg,     moved_next;
    logic [REQ_W-1:0]  idx_reg,       idx_next;
    logic [DATA_W-1:0] wbuf_reg,      wbuf_next;
    logic [DATA_W-1:0] rbuf_reg,      rbuf_next;
    logic [PTR_W-1:0]  rd_ptr_reg,    rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg,    wr_ptr_next;
    logic [CNT_W-1:0]  cnt_reg,       cnt_next;
    logic              cap_valid_reg, cap_valid_next;
    logic [2:0]        cap_idx_reg,   cap_idx_next;

    logic [REQ_W-1:0]  req_sat;
    logic [WIDE_W-1:0] avail;
    logic [WIDE_W-1:0] free_wide;
    logic [REQ_W-1:0]  moved_calc;
    logic [PTR_W-1:0]  cur_ptr;
    logic [PTR_W-1:0]  inc_ptr;
    logic              ram_en;
    logic [7:0]        ram_q;

    // shared pointer incrementer, serves whichever pointer the current beat uses
    assign cur_ptr = (act_reg == brf_pkg::ACT_WRITE) ? wr_ptr_reg : rd_ptr_reg;
    assign inc_ptr = (cur_ptr == LAST_PTR) ? '0 : cur_ptr + PTR_W'(1);

    assign req_sat   = (cmd.byte_count > MAX_REQ) ? MAX_REQ : cmd.byte_count;
    assign free_wide = WIDE_W'(DEPTH) - WIDE_W'(cnt_reg);
    assign avail     = (cmd.action == brf_pkg::ACT_WRITE) ? free_wide : WIDE_W'(cnt_reg);
    assign moved_calc = (WIDE_W'(req_sat) < avail) ? req_sat : avail[REQ_W-1:0];

    assign ram_en = (state_reg == S_RUN) && (idx_reg != moved_reg);

    brf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (act_reg),
        .addr  (cur_ptr),
        .wdata (wbuf_reg[7:0]),
        .rdata (ram_q)
    );

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.read_data     = rbuf_reg;
        res.moved_count   = moved_reg;
        res.short_flag    = (moved_reg < req_reg);
        res.space_left    = free_wide[brf_pkg::FREE_W-1:0];
        res.empty_flag    = (cnt_reg == '0);
        res.full_flag_out = (cnt_reg == FULL_CNT);
    end

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        req_next       = req_reg;
        moved_next     = moved_reg;
        idx_next       = idx_reg;
        wbuf_next      = wbuf_reg;
        rbuf_next      = rbuf_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        cnt_next       = cnt_reg;
        cap_valid_next = 1'b0;
        cap_idx_next   = cap_idx_reg;

        // read data lands in the cycle after the address beat
        if (cap_valid_reg)
        begin
            rbuf_next[{cap_idx_reg, 3'b000} +: 8] = ram_q;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    act_next   = cmd.action;
                    req_next   = req_sat;
                    moved_next = moved_calc;
                    idx_next   = '0;
                    wbuf_next  = cmd.write_data;
                    rbuf_next  = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (idx_reg != moved_reg)
                begin
                    idx_next = idx_reg + REQ_W'(1);
                    if (act_reg == brf_pkg::ACT_WRITE)
                    begin
                        wr_ptr_next = inc_ptr;
                        wbuf_next   = wbuf_reg >> 8;
                        cnt_next    = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        rd_ptr_next    = inc_ptr;
                        cnt_next       = cnt_reg - CNT_W'(1);
                        cap_valid_next = 1'b1;
                        cap_idx_next   = idx_reg[2:0];
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            cnt_reg       <= '0;
            cap_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            cnt_reg       <= cnt_next;
            cap_valid_reg <= cap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        req_reg     <= req_next;
        moved_reg   <= moved_next;
        idx_reg     <= idx_next;
        wbuf_reg    <= wbuf_next;
        rbuf_reg    <= rbuf_next;
        cap_idx_reg <= cap_idx_next;
    end

endmodule
`default_nettype wire

/* rtl/byte_ring_fifo.sv */
// Byte ring FIFO top level: command channel, sequencer and result register.
//
// Usage: each beat on in_ch either writes up to MAX_BYTES bytes (action = 1,
// first byte in write_data[7:0]) or reads up to MAX_BYTES bytes (action = 0).
// A byte_count above MAX_BYTES counts as MAX_BYTES. Every command yields one
// beat on out_ch with the bytes read (low byte first, unused bytes zero), the
// bytes moved, a short flag, the free space and the empty and full flags
// after the command.
// Timing: a command occupies the block from acceptance through S_RUN and S_DONE
// until the next acceptance; bytes go one per cycle through the single-port
// byte RAM. The result is registered into the out_ch output register as the
// command leaves S_DONE. in_ch.ready is low while a command is in progress.
// Reset: pointers and fill count clear to an empty buffer; RAM contents are
// left as they are and need no clearing pass.
// Stall: a held result stays in the output register while the next command
// is taken; that command then waits in its final cycle until the output
// register frees up.
`timescale 1ns / 1ps
`default_nettype none
module byte_ring_fifo #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BYTES = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    brf_in_if.sink     in_ch,
    brf_out_if.source  out_ch
);

    brf_pkg::brf_cmd_t    cmd;
    brf_pkg::brf_result_t res;
    brf_pkg::brf_result_t out_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 res_valid;
    logic                 res_ready;

    assign cmd.action     = in_ch.action;
    assign cmd.byte_count = in_ch.byte_count;
    assign cmd.write_data = in_ch.write_data;

    brf_seq #(
        .DEPTH     (DEPTH),
        .MAX_BYTES (MAX_BYTES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (in_ch.valid),
        .cmd_ready (in_ch.ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.read_data     = out_reg.read_data;
    assign out_ch.moved_count   = out_reg.moved_count;
    assign out_ch.short_flag    = out_reg.short_flag;
    assign out_ch.space_left    = out_reg.space_left;
    assign out_ch.empty_flag    = out_reg.empty_flag;
    assign out_ch.full_flag_out = out_reg.full_flag_out;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("command accepted on back-to-back cycles");

    a_moved_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (32'(out_ch.moved_count) <= 32'(MAX_BYTES)))
        else $error("moved count exceeds per-beat limit");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.empty_flag && out_ch.full_flag_out))
        else $error("buffer reported empty and full together");

    a_short_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.short_flag) |-> (out_ch.empty_flag || out_ch.full_flag_out))
        else $error("short transfer without empty or full buffer");

endmodule
`default_nettype wire

/* test/tb_byte_ring_fifo.sv */
// Self-checking testbench for the byte ring FIFO: shadow ring model, driver, monitor, phases.
`timescale 1ns / 1ps
module tb_byte_ring_fifo;

    localparam int RING_DEPTH = 1024;
    localparam int BEAT_MAX   = 8;
    localparam int HOLD_CYC   = 400;
    localparam int TAIL_CYC   = 20;

    logic clk;
    logic rst_n;

    brf_in_if  in_ch ();
    brf_out_if out_ch ();

    byte_ring_fifo #(
        .DEPTH     (RING_DEPTH),
        .MAX_BYTES (BEAT_MAX)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // shadow copy of the ring
    logic [7:0] shadow_mem [0:RING_DEPTH-1];
    int         rd_ptr;
    int         wr_ptr;
    logic       full_mk;

    brf_pkg::brf_cmd_t    cmd_q [$];
    brf_pkg::brf_result_t fifo_exp_q [$];

    int idle_pct;
    int stall_pct;
    int err_cnt;
    int beat_cnt;
    int wr_cnt;
    int rd_cnt;
    int short_cnt;
    int full_cnt;
    int empty_rd_cnt;

    logic hold_trig;
    logic hold_seen;
    int   hold_left;

    function automatic int fifo_level();
        if (full_mk)
            return RING_DEPTH;
        return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
    endfunction

    // Applies one command to the shadow ring and returns the result beat it should produce.
    function automatic brf_pkg::brf_result_t predict_fifo(input brf_pkg::brf_cmd_t cmd);
        brf_pkg::brf_result_t r;
        int          req;
        int          avail;
        int          moved;
        int          held;
        r     = '0;
        req   = (cmd.byte_count > BEAT_MAX) ? BEAT_MAX : int'(cmd.byte_count);
        held  = fifo_level();
        if (cmd.action == brf_pkg::ACT_WRITE)
        begin
            wr_cnt++;
            avail = RING_DEPTH - held;
            moved = (req < avail) ? req : avail;
            for (int i = 0; i < moved; i++)
            begin
                shadow_mem[wr_ptr] = cmd.write_data[8*i +: 8];
                wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            end
            if (moved > 0 && wr_ptr == rd_ptr)
            begin
                full_mk = 1'b1;
                full_cnt++;
            end
        end
        else
        begin
            rd_cnt++;
            avail = held;
            moved = (req < avail) ? req : avail;
            if (held == 0)
                empty_rd_cnt++;
            for (int i = 0; i < moved; i++)
            begin
                r.read_data[8*i +: 8] = shadow_mem[rd_ptr];
                rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            end
            if (moved > 0)
                full_mk = 1'b0;
        end
        held            = fifo_level();
        r.moved_count   = brf_pkg::REQ_W'(moved);
        r.short_flag    = (moved < req);
        r.space_left    = brf_pkg::FREE_W'(RING_DEPTH - held);
        r.empty_flag    = (held == 0);
        r.full_flag_out = full_mk;
        if (moved < req)
            short_cnt++;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_cnt < 30)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s got %0h want %0h", beat_cnt, name, got, want));
    endtask

    function automatic brf_pkg::brf_cmd_t make_cmd(input logic act, input int cnt,
                                                   input logic [63:0] data);
        brf_pkg::brf_cmd_t c;
        c.action     = act;
        c.byte_count = brf_pkg::REQ_W'(cnt);
        c.write_data = data;
        return c;
    endfunction

    function automatic brf_pkg::brf_cmd_t rand_cmd(input int wr_pct);
        logic act;
        act = ($urandom_range(99) < wr_pct) ? brf_pkg::ACT_WRITE : brf_pkg::ACT_READ;
        return make_cmd(act, $urandom_range(15), {$urandom, $urandom});
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Command driver: a beat stays on the bus until accepted, then the next is popped unless an idle gap is drawn.
    always @(posedge clk or negedge rst_n)
    begin
        brf_pkg::brf_cmd_t nxt;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                fifo_exp_q.push_back(predict_fifo({in_ch.action, in_ch.byte_count,
                                                   in_ch.write_data}));
            if (in_ch.valid && !in_ch.ready)
            begin
                // hold the current beat
            end
            else if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                nxt = cmd_q.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.action     <= nxt.action;
                in_ch.byte_count <= nxt.byte_count;
                in_ch.write_data <= nxt.write_data;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started by a toggle of hold_trig.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_trig != hold_seen)
        begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_CYC;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= (hold_left == 0) && (hold_trig == hold_seen) &&
                            ($urandom_range(99) >= stall_pct);
    end

    // Result monitor
    always @(posedge clk)
    begin
        brf_pkg::brf_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (fifo_exp_q.size() == 0)
            begin
                report_mismatch("result beat with nothing expected");
            end
            else
            begin
                want = fifo_exp_q.pop_front();
                check_field("read_data", out_ch.read_data, want.read_data);
                check_field("moved_count", out_ch.moved_count, want.moved_count);
                check_field("short_flag", out_ch.short_flag, want.short_flag);
                check_field("space_left", out_ch.space_left, want.space_left);
                check_field("empty_flag", out_ch.empty_flag, want.empty_flag);
                check_field("full_flag_out", out_ch.full_flag_out, want.full_flag_out);
            end
            beat_cnt++;
        end
    end

    task automatic wait_drained();
        while (cmd_q.size() != 0 || in_ch.valid || fifo_exp_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int n, input int wr_pct, input int idle, input int stall);
        @(negedge clk);
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++)
            cmd_q.push_back(rand_cmd(wr_pct));
        wait_drained();
    endtask

    initial
    begin
        in_ch.valid      = 1'b0;
        in_ch.action     = brf_pkg::ACT_READ;
        in_ch.byte_count = '0;
        in_ch.write_data = '0;
        out_ch.ready     = 1'b0;
        hold_trig        = 1'b0;
        rd_ptr           = 0;
        wr_ptr           = 0;
        full_mk          = 1'b0;
        idle_pct         = 0;
        stall_pct        = 0;
        err_cnt          = 0;
        beat_cnt         = 0;
        wr_cnt           = 0;
        rd_cnt           = 0;
        short_cnt        = 0;
        full_cnt         = 0;
        empty_rd_cnt     = 0;
        rst_n            = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty reads, zero-byte ops, saturated counts, data extremes
        cmd_q.push_back(make_cmd(brf_pkg::ACT_READ, 0, '0));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_READ, 8, '1));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_READ, 15, '0));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_WRITE, 0, '1));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_WRITE, 1, 64'hA5));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_WRITE, 8, '1));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_WRITE, 15, '0));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_WRITE, 8, 64'h0123_4567_89AB_CDEF));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_READ, 0, '1));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_READ, 1, '0));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_READ, 15, '0));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_READ, 8, '0));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_READ, 8, '0));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_READ, 3, '0));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_WRITE, 7, {$urandom, $urandom}));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_WRITE, 9, {$urandom, $urandom}));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_READ, 4, '0));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_WRITE, 0, '1));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_READ, 15, '0));
        cmd_q.push_back(make_cmd(brf_pkg::ACT_READ, 2, '0));
        wait_drained();

        run_phase(200, 80, 0, 0);

        // push to full and beyond: overflowing writes, then mixed traffic at the top
        @(negedge clk);
        idle_pct  = 82;
        stall_pct = 0;
        for (int i = 0; i < 160; i++)
            cmd_q.push_back(make_cmd(brf_pkg::ACT_WRITE, $urandom_range(8, 15),
                                     {$urandom, $urandom}));
        for (int i = 0; i < 40; i++)
            cmd_q.push_back(rand_cmd(60));
        wait_drained();

        run_phase(200, 20, 0, 82);
        run_phase(200, 50, 34, 34);

        // long receiver hold-off while the sender keeps offering
        @(negedge clk);
        idle_pct  = 0;
        stall_pct = 0;
        for (int i = 0; i < 150; i++)
            cmd_q.push_back(rand_cmd(50));
        hold_trig = ~hold_trig;
        wait_drained();

        // drain toward empty, reads past the end of stored data
        run_phase(200, 30, 34, 34);

        repeat (TAIL_CYC) @(negedge clk);
        $display("covered %0d writes and %0d reads (%0d on an empty ring), %0d result beats",
                 wr_cnt, rd_cnt, empty_rd_cnt, beat_cnt);
        $display("%0d short results, ring filled %0d times", short_cnt, full_cnt);
        if (err_cnt == 0)
            $display("tb_byte_ring_fifo: clean");
        else
            $display("tb_byte_ring_fifo: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout waiting for result beats");
        $display("tb_byte_ring_fifo: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/brf_pkg.sv
rtl/brf_if.sv
rtl/brf_ram.sv
rtl/brf_seq.sv
rtl/byte_ring_fifo.sv
test/tb_byte_ring_fifo.sv
